// File: design/set_assoc_lru_cache_tags_unit_defines.svh
// Assertion macros for the cache tag unit.
// Used by the top level only; no other dependencies.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_UNIT_DEFINES_SVH

// Check that a condition implies something in the same cycle.
`define SALC_ASSERT_IMP(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Check that a condition implies something in the next cycle.
`define SALC_ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

// File: design/salc_pkg.sv
// Shared types and constants of the cache tag unit.
// No dependencies.
package salc_pkg;
   localparam int SetsDefault     = 64;
   localparam int WaysDefault     = 8;
   localparam int AddrBitsDefault = 32;
   localparam int ShiftWidth      = 4;
   localparam logic [ShiftWidth-1:0] ShiftReset = 4'd6;
   localparam int SetFieldWidth   = 6;
   localparam int WayFieldWidth   = 3;

   // Access kinds.
   localparam logic [1:0] KindRead     = 2'd0;
   localparam logic [1:0] KindWrite    = 2'd1;
   localparam logic [1:0] KindPrefetch = 2'd2;

   // Line status codes.
   localparam logic [1:0] StInvalid = 2'd0;
   localparam logic [1:0] StValid   = 2'd1;
   localparam logic [1:0] StDirty   = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CLEAR,
      PH_LOOKUP,
      PH_HOLD
   } phase_type;
endpackage

// File: design/salc_ram.sv
// Generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
module salc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: design/set_assoc_lru_cache_tags_unit.sv
// Top level of the cache tag unit: one row per set holds every way's tag,
// status, top mark and rank. Depends on salc_pkg, salc_ram and the defines header.
//
//  channel | ports                                   | direction
//  req     | req_valid, req_stall, address/kind/top  | in
//  rsp     | rsp_valid, rsp_stall, hit..way_used     | out
//  csr     | csr_wr_en, csr_wr_data (block_shift)    | in
//
// Each access first reads the set row, then compares it, writes the row back and
// loads the response register; no new access is taken until that is done.
// After reset a clearing pass writes every row once, no access taken.
// A stalled response holds in its register; one more access is taken meanwhile
// and waits after its row read until the register frees.
`include "set_assoc_lru_cache_tags_unit_defines.svh"
module set_assoc_lru_cache_tags_unit
   import salc_pkg::*;
#(
   parameter int Sets     = SetsDefault,
   parameter int Ways     = WaysDefault,
   parameter int AddrBits = AddrBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [ShiftWidth-1:0]    csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [31:0]              req_address,
   input  logic [1:0]               req_kind,
   input  logic                     req_top_flag,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic                     rsp_evicted,
   output logic                     rsp_wrote_back,
   output logic                     rsp_victim_was_top,
   output logic [SetFieldWidth-1:0] rsp_set_index,
   output logic [WayFieldWidth-1:0] rsp_way_used
);
   localparam int SetBits  = (Sets > 1) ? $clog2(Sets) : 1;
   localparam int WayBits  = (Ways > 1) ? $clog2(Ways) : 1;
   localparam int RankBits = WayBits;
   localparam int CntBits  = $clog2(Sets + 1);
   localparam int WayW     = AddrBits + 2 + 1 + RankBits;
   localparam int RowW     = WayW * Ways;

   typedef struct packed {
      logic [AddrBits-1:0] tag;
      logic [1:0]          status;
      logic                top;
      logic [RankBits-1:0] rank;
   } way_type;

   phase_type             phase_ff, phase_in;
   logic [ShiftWidth-1:0] shift_ff;
   logic [CntBits-1:0]    clr_ff, clr_in;
   logic [AddrBits-1:0]   blk_ff, blk_in;
   logic [1:0]            kind_ff;
   logic                  top_ff;
   logic                  hit_ff, ev_ff, wb_ff, vt_ff;
   logic [WayBits-1:0]    way_ff;
   logic [SetBits-1:0]    set_ff;
   logic [SetBits-1:0]    set_out_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SetBits-1:0]    set_in;
   logic                  res_en;
   logic                  ram_we;
   logic [SetBits-1:0]    ram_wa;
   logic [RowW-1:0]       ram_wd, ram_rd;
   way_type               ways_rd [Ways];
   way_type               ways_wr [Ways];
   logic                  hit_c, ev_c, wb_c, vt_c, found_inv;
   logic [WayBits-1:0]    way_c, hit_w, inv_w, lru_w;
   logic [RankBits-1:0]   best, old_rank;
   logic                  sel_valid;
   logic [AddrBits-1:0]   addr_m;

   salc_ram #(.Width(RowW), .Depth(Sets)) u_row (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(set_in),
      .rd_data(ram_rd)
   );

   // Config register.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= ShiftReset;
      end else if (csr_wr_en) begin
         shift_ff <= csr_wr_data;
      end
   end

   // Block number and set of the incoming access.
   always_comb begin
      addr_m = AddrBits'(req_address);
      blk_in = addr_m >> shift_ff;
      set_in = (phase_ff == PH_IDLE) ? SetBits'(blk_in % Sets) : set_ff;
      if (Sets == 1) begin
         set_in = '0;
      end
   end

   // Lookup, victim choice, rank update and new tag, status and top mark of the chosen way.
   always_comb begin
      for (int i = 0; i < Ways; i++) begin
         ways_rd[i] = ram_rd[i*WayW +: WayW];
      end
      hit_c = 1'b0; hit_w = '0; found_inv = 1'b0; inv_w = '0;
      lru_w = '0; best = '0;
      for (int i = Ways - 1; i >= 0; i--) begin
         if (ways_rd[i].status != StInvalid && ways_rd[i].tag == blk_ff) begin
            hit_c = 1'b1; hit_w = WayBits'(i);
         end
         if (ways_rd[i].status == StInvalid) begin
            found_inv = 1'b1; inv_w = WayBits'(i);
         end
      end
      for (int i = 0; i < Ways; i++) begin
         if (ways_rd[i].rank >= best) begin
            best = ways_rd[i].rank; lru_w = WayBits'(i);
         end
      end
      way_c = hit_c ? hit_w : (found_inv ? inv_w : lru_w);
      ev_c = !hit_c && !found_inv;
      wb_c = ev_c && ways_rd[way_c].status == StDirty;
      vt_c = ev_c && ways_rd[way_c].top;
      sel_valid = ways_rd[way_c].status != StInvalid;
      old_rank = ways_rd[way_c].rank;
      for (int i = 0; i < Ways; i++) begin
         ways_wr[i] = ways_rd[i];
         if (WayBits'(i) != way_c && ways_rd[i].status != StInvalid
             && (!sel_valid || ways_rd[i].rank < old_rank)) begin
            ways_wr[i].rank = ways_rd[i].rank + 1'b1;
         end
      end
      ways_wr[way_c].rank = '0;
      if (hit_c) begin
         if (!top_ff) ways_wr[way_c].top = 1'b0;
         if (kind_ff == KindWrite) ways_wr[way_c].status = StDirty;
      end else begin
         ways_wr[way_c].tag = blk_ff;
         ways_wr[way_c].top = top_ff;
         ways_wr[way_c].status = (kind_ff == KindWrite) ? StDirty : StValid;
      end
   end

   // Sequencer: clear pass, then idle / lookup, holding while the response is stuck.
   always_comb begin
      phase_in = phase_ff;
      clr_in = clr_ff;
      res_en = 1'b0;
      ram_we = 1'b0;
      ram_wa = set_ff;
      ram_wd = '0;
      for (int i = 0; i < Ways; i++) begin
         ram_wd[i*WayW +: WayW] = ways_wr[i];
      end
      req_stall = 1'b1;
      unique case (phase_ff) inside
         PH_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = SetBits'(clr_ff);
            ram_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CntBits'(Sets - 1)) phase_in = PH_IDLE;
         end
         PH_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) phase_in = PH_LOOKUP;
         end
         PH_LOOKUP, PH_HOLD: begin
            // Write back and load the response once its register frees
            if (!rsp_valid_ff || !rsp_stall) begin
               ram_we = 1'b1;
               res_en = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_HOLD;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // Response register occupancy: fill on load, drop when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_en) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture access fields and results.
   always_ff @(posedge clock) begin
      if (phase_ff == PH_IDLE && req_valid) begin
         blk_ff  <= blk_in;
         set_ff  <= set_in;
         kind_ff <= req_kind;
         top_ff  <= req_top_flag;
      end
      if (res_en) begin
         hit_ff <= hit_c; ev_ff <= ev_c; wb_ff <= wb_c; vt_ff <= vt_c;
         way_ff <= way_c;
         set_out_ff <= set_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_evicted        = ev_ff;
   assign rsp_wrote_back     = wb_ff;
   assign rsp_victim_was_top = vt_ff;
   assign rsp_set_index      = SetFieldWidth'(set_out_ff);
   assign rsp_way_used       = WayFieldWidth'(way_ff);

   `SALC_ASSERT_IMP(a_wb_ev, clock, reset, rsp_valid, !rsp_wrote_back || rsp_evicted, "wb without evict")
   `SALC_ASSERT_IMP(a_hit_ev, clock, reset, rsp_valid, !(rsp_hit && rsp_evicted), "hit and evict")
   `SALC_ASSERT_NEXT(a_lookup, clock, reset, !req_stall && req_valid, phase_ff == PH_LOOKUP, "no lookup")
   `SALC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped")
endmodule

// File: dv/tb.sv
// Self-checking testbench for set_assoc_lru_cache_tags_unit (tag/LRU store).
// Depends on salc_pkg and the unit RTL; predicts every response beat in-line.
`timescale 1ns / 1ps
module tb
   import salc_pkg::*;
();

   localparam int NSets = SetsDefault;
   localparam int NWays = WaysDefault;

   typedef struct packed {
      logic                     hit;
      logic                     evicted;
      logic                     wrote_back;
      logic                     victim_was_top;
      logic [SetFieldWidth-1:0] set_index;
      logic [WayFieldWidth-1:0] way_used;
   } lookup_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [ShiftWidth-1:0]    csr_wr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [31:0]              req_address = '0;
   logic [1:0]               req_kind = KindRead;
   logic                     req_top_flag = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_hit, rsp_evicted, rsp_wrote_back, rsp_victim_was_top;
   logic [SetFieldWidth-1:0] rsp_set_index;
   logic [WayFieldWidth-1:0] rsp_way_used;

   // Shadow copy of the tag store
   logic [31:0]           tag_mirror    [NSets][NWays];
   logic [1:0]            status_mirror [NSets][NWays];
   logic                  top_mirror    [NSets][NWays];
   int unsigned           rank_mirror   [NSets][NWays];
   logic [ShiftWidth-1:0] shift_mirror;

   lookup_type  lookup_q[$];
   int          errors = 0;
   int          n_hits = 0, n_evicts = 0, n_wbacks = 0, n_beats = 0;
   bit          no_idle = 1'b0;
   int          rsp_hold = 0;
   longint      cycle_count = 0;

   set_assoc_lru_cache_tags_unit u_top (.*);

   always #5 clock = ~clock;

   // Age the valid ways younger than way w, then make w most recent
   function automatic void touch_way(int s, int w);
      int unsigned old_rank;
      old_rank = (status_mirror[s][w] != StInvalid) ? rank_mirror[s][w] : NWays;
      for (int v = 0; v < NWays; v++)
         if (v != w && status_mirror[s][v] != StInvalid && rank_mirror[s][v] < old_rank)
            rank_mirror[s][v]++;
      rank_mirror[s][w] = 0;
   endfunction

   function automatic lookup_type predict_lookup(logic [31:0] addr, logic [1:0] kind,
                                                 logic top);
      lookup_type  r;
      logic [31:0] blk;
      int          s, way;
      int unsigned best;
      blk  = addr >> shift_mirror;
      s    = blk % NSets;
      way  = -1;
      r    = '0;
      for (int w = 0; w < NWays; w++)
         if (way < 0 && status_mirror[s][w] != StInvalid && tag_mirror[s][w] == blk)
            way = w;
      if (way >= 0) begin
         r.hit = 1'b1;
         if (!top) top_mirror[s][way] = 1'b0;
         touch_way(s, way);
         if (kind == KindWrite) status_mirror[s][way] = StDirty;
      end else begin
         for (int w = 0; w < NWays; w++)
            if (way < 0 && status_mirror[s][w] == StInvalid) way = w;
         if (way < 0) begin
            best = 0;
            way  = 0;
            for (int w = 0; w < NWays; w++)
               if (rank_mirror[s][w] >= best) begin
                  best = rank_mirror[s][w];
                  way  = w;
               end
            r.evicted        = 1'b1;
            r.wrote_back     = (status_mirror[s][way] == StDirty);
            r.victim_was_top = top_mirror[s][way];
         end
         touch_way(s, way);
         tag_mirror[s][way]    = blk;
         status_mirror[s][way] = (kind == KindWrite) ? StDirty : StValid;
         top_mirror[s][way]    = top;
      end
      r.set_index = s[SetFieldWidth-1:0];
      r.way_used  = way[WayFieldWidth-1:0];
      return r;
   endfunction

   // Send one access beat; called and returning at a rising edge
   task automatic send_access(logic [31:0] addr, logic [1:0] kind, logic top);
      if (!no_idle && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 19);
      end
      req_valid    <= 1'b1;
      req_address  <= addr;
      req_kind     <= kind;
      req_top_flag <= top;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lookup_q.push_back(predict_lookup(addr, kind, top));
   endtask

   // Drop valid and wait until every expected response has drained
   task automatic drain();
      req_valid <= 1'b0;
      while (lookup_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_shift(logic [ShiftWidth-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      shift_mirror = value;
   endtask

   // Mostly addresses crowding a few sets with a small tag pool; some raw noise
   function automatic logic [31:0] pick_address();
      logic [31:0] blk, offs;
      if ($urandom_range(99) < 15) return $urandom;
      blk  = ($urandom_range(15) << SetFieldWidth) | $urandom_range(3);
      offs = $urandom & ((32'd1 << shift_mirror) - 1);
      return (blk << shift_mirror) | offs;
   endfunction

   task automatic run_random(int count);
      for (int i = 0; i < count; i++)
         send_access(pick_address(), 2'($urandom_range(3)), 1'($urandom_range(1)));
   endtask

   task automatic test_directed();
      send_access(32'h0000_0000, KindRead, 1'b0);
      send_access(32'hFFFF_FFFF, KindWrite, 1'b1);
      send_access(32'h0000_0010, KindPrefetch, 1'b1);
      send_access(32'h0000_0000, 2'd3, 1'b1);
      // Fill set 0, then push past it to force evictions
      for (int t = 1; t < 10; t++)
         send_access(32'(t << 12), (t % 2) ? KindWrite : KindPrefetch, t[0]);
      send_access(32'h0000_1000, KindRead, 1'b0);
      send_access(32'h0000_2000, KindPrefetch, 1'b0);
      for (int t = 10; t < 16; t++)
         send_access(32'(t << 12), KindRead, 1'b1);
      send_access(32'hFFFF_FFC0, KindPrefetch, 1'b0);
      send_access(32'hFFFF_FFC4, KindWrite, 1'b1);
      drain();
   endtask

   task automatic test_shift_sweep();
      write_shift(4'd0);
      run_random(160);
      drain();
      write_shift(4'd12);
      no_idle = 1'b1;
      run_random(160);
      no_idle = 1'b0;
      drain();
      write_shift(4'd15);
      run_random(120);
      drain();
      write_shift(4'd6);
      run_random(250);
      drain();
   endtask

   // Hold the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      write_shift(4'd13);
      rsp_hold = 300;
      run_random(150);
      drain();
   endtask

   // Response stall: random idling, plus a counted hold-off
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 19);
      end
   end

   // Compare each response beat with the oldest prediction
   always @(posedge clock) begin
      lookup_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_hit, rsp_evicted, rsp_wrote_back, rsp_victim_was_top,
                rsp_set_index, rsp_way_used};
         if (lookup_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected response beat %p", $time, got);
         end else begin
            want = lookup_q.pop_front();
            n_beats++;
            n_hits   += want.hit;
            n_evicts += want.evicted;
            n_wbacks += want.wrote_back;
            if (got !== want) begin
               errors++;
               $display("%0t: mismatch expected %p actual %p", $time, want, got);
            end
         end
      end
   end

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("%0t: timeout with %0d responses pending", $time, lookup_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < NSets; s++)
         for (int w = 0; w < NWays; w++) begin
            tag_mirror[s][w]    = '0;
            status_mirror[s][w] = StInvalid;
            top_mirror[s][w]    = 1'b0;
            rank_mirror[s][w]   = 0;
         end
      shift_mirror = ShiftReset;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_shift_sweep();
      test_backpressure();
      $display("Covered %0d accesses over shifts 0/6/12/13/15: %0d hits, %0d evictions,",
               n_beats, n_hits, n_evicts);
      $display("%0d write-backs, with a long response hold-off.", n_wbacks);
      if (errors == 0 && lookup_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// File: files.f
+incdir+design
design/salc_pkg.sv
design/salc_ram.sv
design/set_assoc_lru_cache_tags_unit.sv
dv/tb.sv
